// ===== rtl/qlu_pkg.sv =====
// Shared constants, field layout, command/status structs and helpers for the
// tabular Q-learning update block. No dependencies.
package qlu_pkg;

    localparam int QLU_NUM_STATES  = 64;
    localparam int QLU_NUM_ACTIONS = 4;

    localparam int QLU_Q_W   = 32;
    localparam int QLU_REG_W = 17;
    localparam logic [QLU_REG_W-1:0] QLU_ONE_Q16 = 17'd65536;

    localparam logic [QLU_REG_W-1:0] QLU_LEARN_RATE_RST   = 17'd6554;
    localparam logic [QLU_REG_W-1:0] QLU_DISCOUNT_RST     = 17'd58982;
    localparam logic [QLU_REG_W-1:0] QLU_EXPLORE_RATE_RST = 17'd6554;

    localparam int QLU_CFG_IDX_W = 2;
    localparam logic [QLU_CFG_IDX_W-1:0] QLU_CFG_LEARN_RATE   = 2'd0;
    localparam logic [QLU_CFG_IDX_W-1:0] QLU_CFG_DISCOUNT     = 2'd1;
    localparam logic [QLU_CFG_IDX_W-1:0] QLU_CFG_EXPLORE_RATE = 2'd2;

    localparam int QLU_STATE_IN_W  = 6;
    localparam int QLU_ACTION_IN_W = 2;
    localparam int QLU_RAND_W      = 16;
    localparam int QLU_STATE_CODES  = 1 << QLU_STATE_IN_W;
    localparam int QLU_ACTION_CODES = 1 << QLU_ACTION_IN_W;

    localparam int QLU_S_TDATA_W = 64;
    localparam int QLU_M_TDATA_W = 40;
    localparam int QLU_M_PAD_W   = QLU_M_TDATA_W - QLU_Q_W - QLU_ACTION_IN_W;

    typedef struct packed {
        logic clear;
        logic latch;
        logic scan_rd;
        logic rd_cur;
        logic cap_cur;
        logic calc_tgt;
        logic mul_step;
        logic wr_q;
        logic load_out;
    } qlu_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic scan_last;
        logic item_learn;
        logic item_explore;
    } qlu_status_t;

    function automatic logic [QLU_REG_W-1:0] clamp_one(input logic [QLU_REG_W-1:0] v);
        return (v > QLU_ONE_Q16) ? QLU_ONE_Q16 : v;
    endfunction

endpackage

// ===== rtl/qlu_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module qlu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/qlu_ctrl.sv =====
// Sequencer for the Q-learning block: clearing pass, row scans, TD update
// steps and output handoff. Depends on qlu_pkg.
module qlu_ctrl import qlu_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    output logic        m_tvalid,
    input  logic        m_tready,
    output qlu_cmd_t    cmd,
    input  qlu_status_t status
);

    localparam logic [3:0] ST_CLEAR   = 4'd0;
    localparam logic [3:0] ST_IDLE    = 4'd1;
    localparam logic [3:0] ST_DECIDE  = 4'd2;
    localparam logic [3:0] ST_SCAN1   = 4'd3;
    localparam logic [3:0] ST_RDCUR   = 4'd4;
    localparam logic [3:0] ST_CAPCUR  = 4'd5;
    localparam logic [3:0] ST_TGT     = 4'd6;
    localparam logic [3:0] ST_MUL     = 4'd7;
    localparam logic [3:0] ST_WRQ     = 4'd8;
    localparam logic [3:0] ST_SCAN2   = 4'd9;
    localparam logic [3:0] ST_SCANEND = 4'd10;
    localparam logic [3:0] ST_DONE    = 4'd11;

    logic [3:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic       out_free;

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clear = 1'b1;
                if (status.clear_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.latch  = 1'b1;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (status.item_learn) state_next = ST_SCAN1;
                else if (status.item_explore) state_next = ST_DONE;
                else state_next = ST_SCAN2;
            end
            ST_SCAN1: begin
                cmd.scan_rd = 1'b1;
                if (status.scan_last) state_next = ST_RDCUR;
            end
            ST_RDCUR: begin
                cmd.rd_cur = 1'b1;
                state_next = ST_CAPCUR;
            end
            ST_CAPCUR: begin
                cmd.cap_cur = 1'b1;
                state_next  = ST_TGT;
            end
            ST_TGT: begin
                cmd.calc_tgt = 1'b1;
                state_next   = ST_MUL;
            end
            ST_MUL: begin
                cmd.mul_step = 1'b1;
                state_next   = ST_WRQ;
            end
            ST_WRQ: begin
                cmd.wr_q   = 1'b1;
                state_next = status.item_explore ? ST_DONE : ST_SCAN2;
            end
            ST_SCAN2: begin
                cmd.scan_rd = 1'b1;
                if (status.scan_last) state_next = ST_SCANEND;
            end
            ST_SCANEND: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.load_out) m_valid_next = 1'b1;
        else if (m_tready) m_valid_next = 1'b0;
        else m_valid_next = m_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// ===== rtl/qlu_datapath.sv =====
// Datapath: item and configuration registers, Q table RAM, row maximum scan,
// TD update arithmetic and output registers. Depends on qlu_pkg and qlu_ram.
module qlu_datapath import qlu_pkg::*; #(
    parameter int NUM_STATES  = QLU_NUM_STATES,
    parameter int NUM_ACTIONS = QLU_NUM_ACTIONS
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_wr_en,
    input  logic [QLU_CFG_IDX_W-1:0] cfg_index,
    input  logic [QLU_REG_W-1:0]     cfg_wdata,
    input  logic [QLU_S_TDATA_W-1:0] s_tdata,
    input  logic                     s_tuser,
    output logic [QLU_M_TDATA_W-1:0] m_tdata,
    output logic                     m_tuser,
    input  qlu_cmd_t                 cmd,
    output qlu_status_t              status
);

    localparam int SW    = $clog2(NUM_STATES);
    localparam int AW    = $clog2(NUM_ACTIONS);
    localparam int DEPTH = NUM_STATES * NUM_ACTIONS;
    localparam int ADW   = $clog2(DEPTH);

    localparam logic signed [49:0] BIAS1   = 50'sd32768;
    localparam logic signed [52:0] BIAS2   = 53'sd32768;
    localparam logic signed [37:0] SAT_MAX = 38'sd2147483647;
    localparam logic signed [37:0] SAT_MIN = -38'sd2147483648;

    logic [SW-1:0] st_lut [QLU_STATE_CODES];
    logic [AW-1:0] act_lut [QLU_ACTION_CODES];

    for (genvar i = 0; i < QLU_STATE_CODES; i++) begin : g_st_lut
        assign st_lut[i] = SW'(i % NUM_STATES);
    end
    for (genvar i = 0; i < QLU_ACTION_CODES; i++) begin : g_act_lut
        assign act_lut[i] = AW'(i % NUM_ACTIONS);
    end

    logic [QLU_STATE_IN_W-1:0]  in_state, in_next_state;
    logic [QLU_ACTION_IN_W-1:0] in_action, in_rand_action;
    logic [QLU_Q_W-1:0]         in_reward;
    logic [QLU_RAND_W-1:0]      in_rand_value;

    assign in_state       = s_tdata[5:0];
    assign in_action      = s_tdata[7:6];
    assign in_reward      = s_tdata[39:8];
    assign in_next_state  = s_tdata[45:40];
    assign in_rand_value  = s_tdata[61:46];
    assign in_rand_action = s_tdata[63:62];

    logic [QLU_REG_W-1:0] learn_rate_reg, discount_reg, explore_rate_reg;
    logic [QLU_REG_W-1:0] alpha_c, gamma_c, eps_c;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            learn_rate_reg   <= QLU_LEARN_RATE_RST;
            discount_reg     <= QLU_DISCOUNT_RST;
            explore_rate_reg <= QLU_EXPLORE_RATE_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                QLU_CFG_LEARN_RATE:   learn_rate_reg   <= cfg_wdata;
                QLU_CFG_DISCOUNT:     discount_reg     <= cfg_wdata;
                QLU_CFG_EXPLORE_RATE: explore_rate_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign alpha_c = clamp_one(learn_rate_reg);
    assign gamma_c = clamp_one(discount_reg);
    assign eps_c   = clamp_one(explore_rate_reg);

    logic                     learn_reg, explore_reg;
    logic [SW-1:0]            s_reg, ns_reg;
    logic [AW-1:0]            a_reg, ra_reg;
    logic signed [QLU_Q_W-1:0] reward_reg;

    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            learn_reg   <= s_tuser;
            explore_reg <= ({1'b0, in_rand_value} < eps_c);
            s_reg       <= st_lut[in_state];
            ns_reg      <= st_lut[in_next_state];
            a_reg       <= act_lut[in_action];
            ra_reg      <= act_lut[in_rand_action];
            reward_reg  <= $signed(in_reward);
        end
    end

    logic [ADW-1:0] clr_addr_reg;
    logic [AW-1:0]  scan_idx_reg;
    logic           pend_reg, pfirst_reg;
    logic [AW-1:0]  pidx_reg;
    logic [SW-1:0]  row;
    logic [ADW-1:0] scan_addr, cur_addr, raddr, waddr;
    logic           ram_we;
    logic signed [QLU_Q_W-1:0] wdata, rdata, written_next;

    assign row       = learn_reg ? ns_reg : s_reg;
    assign scan_addr = ADW'(row) * ADW'(NUM_ACTIONS) + ADW'(scan_idx_reg);
    assign cur_addr  = ADW'(s_reg) * ADW'(NUM_ACTIONS) + ADW'(a_reg);
    assign raddr     = cmd.rd_cur ? cur_addr : scan_addr;
    assign ram_we    = cmd.clear || cmd.wr_q;
    assign waddr     = cmd.clear ? clr_addr_reg : cur_addr;
    assign wdata     = cmd.clear ? '0 : written_next;

    assign status.clear_last   = (clr_addr_reg == ADW'(DEPTH - 1));
    assign status.scan_last    = (scan_idx_reg == AW'(NUM_ACTIONS - 1));
    assign status.item_learn   = learn_reg;
    assign status.item_explore = explore_reg;

    qlu_ram #(
        .WIDTH (QLU_Q_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
            scan_idx_reg <= '0;
            pend_reg     <= 1'b0;
        end else begin
            if (cmd.clear && !status.clear_last) clr_addr_reg <= clr_addr_reg + ADW'(1);
            if (cmd.scan_rd) begin
                scan_idx_reg <= status.scan_last ? '0 : scan_idx_reg + AW'(1);
            end
            pend_reg <= cmd.scan_rd;
        end
    end

    logic signed [QLU_Q_W-1:0] best_val_reg;
    logic [AW-1:0]             best_idx_reg;

    always_ff @(posedge aclk) begin
        pidx_reg   <= scan_idx_reg;
        pfirst_reg <= (scan_idx_reg == '0);
        if (pend_reg && (pfirst_reg || rdata > best_val_reg)) begin
            best_val_reg <= rdata;
            best_idx_reg <= pidx_reg;
        end
    end

    logic signed [QLU_Q_W-1:0] cur_reg, written_reg;
    logic signed [49:0]        prod1_reg, rnd1_full;
    logic signed [33:0]        gp;
    logic signed [34:0]        delta_reg, delta_next;
    logic signed [52:0]        prod2_reg, rnd2_full;
    logic signed [36:0]        ad;
    logic signed [37:0]        sum;
    logic signed [17:0]        alpha_s, gamma_s;

    assign alpha_s    = $signed({1'b0, alpha_c});
    assign gamma_s    = $signed({1'b0, gamma_c});
    assign rnd1_full  = (prod1_reg + BIAS1) >>> 16;
    assign gp         = 34'(rnd1_full);
    assign delta_next = 35'(reward_reg) + 35'(gp) - 35'(cur_reg);
    assign rnd2_full  = (prod2_reg + BIAS2) >>> 16;
    assign ad         = 37'(rnd2_full);
    assign sum        = 38'(cur_reg) + 38'(ad);

    always_comb begin
        if (sum > SAT_MAX) written_next = 32'sh7FFFFFFF;
        else if (sum < SAT_MIN) written_next = 32'sh80000000;
        else written_next = 32'(sum);
    end

    always_ff @(posedge aclk) begin
        if (cmd.cap_cur) begin
            cur_reg   <= rdata;
            prod1_reg <= 50'(best_val_reg) * 50'(gamma_s);
        end
        if (cmd.calc_tgt) delta_reg <= delta_next;
        if (cmd.mul_step) prod2_reg <= 53'(delta_reg) * 53'(alpha_s);
        if (cmd.wr_q) written_reg <= written_next;
    end

    logic [QLU_ACTION_IN_W-1:0] out_act_reg;
    logic [QLU_Q_W-1:0]         out_val_reg;
    logic                       out_expl_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_act_reg  <= explore_reg ? QLU_ACTION_IN_W'(ra_reg)
                                        : QLU_ACTION_IN_W'(best_idx_reg);
            out_val_reg  <= learn_reg ? written_reg : '0;
            out_expl_reg <= explore_reg;
        end
    end

    assign m_tdata = {{QLU_M_PAD_W{1'b0}}, out_val_reg, out_act_reg};
    assign m_tuser = out_expl_reg;

endmodule

// ===== rtl/tabular_q_learning_update.sv =====
// Top level of the tabular Q-learning update block: controller plus datapath.
// Depends on qlu_pkg, qlu_ctrl, qlu_datapath and qlu_ram.
//
// After reset the block runs a clearing pass over all NUM_STATES*NUM_ACTIONS
// entries that zeroes the Q table; s_tready stays low until it ends, while
// configuration writes are taken throughout. Items are handled one at a time;
// a row maximum scan walks the single-read table RAM one action per cycle. A
// select-only item scans its state row unless it explores; a learn item covers
// the scan of the next state row, the two dependent multiplies, the write back
// and, unless it explores, the rescan for the greedy choice. A finished result
// waits in the output register while the next transaction is accepted.
module tabular_q_learning_update import qlu_pkg::*; #(
    parameter int NUM_STATES  = QLU_NUM_STATES,
    parameter int NUM_ACTIONS = QLU_NUM_ACTIONS
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_wr_en,
    input  logic [QLU_CFG_IDX_W-1:0] cfg_index,
    input  logic [QLU_REG_W-1:0]     cfg_wdata,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    // [5:0] state_index, [7:6] action_taken, [39:8] reward,
    // [45:40] next_state_index, [61:46] rand_value, [63:62] rand_action
    input  logic [QLU_S_TDATA_W-1:0] s_tdata,
    // [0] cmd
    input  logic                     s_tuser,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    // [1:0] chosen_action, [33:2] updated_value, [39:34] zero
    output logic [QLU_M_TDATA_W-1:0] m_tdata,
    // [0] explored
    output logic                     m_tuser
);

    qlu_cmd_t    cmd_bus;
    qlu_status_t status_bus;

    qlu_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd_bus),
        .status   (status_bus)
    );

    qlu_datapath #(
        .NUM_STATES  (NUM_STATES),
        .NUM_ACTIONS (NUM_ACTIONS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cmd       (cmd_bus),
        .status    (status_bus)
    );

    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_bus.clear |-> !s_tready)
        else $error("item accepted during clearing pass");

    a_write_only_learn: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_bus.wr_q |-> status_bus.item_learn)
        else $error("table written for a select-only transaction");

    a_select_zero_value: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd_bus.load_out && !status_bus.item_learn) |=> (m_tdata[33:2] == 32'd0))
        else $error("select-only result carries a nonzero value");

    a_load_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_bus.load_out |=> m_tvalid)
        else $error("loaded result not presented");

endmodule

// ===== test/tabular_q_learning_update_test.sv =====
`timescale 1ns / 100ps
// Self-checking bench for tabular_q_learning_update: predicts every result from
// its own Q table and register copies and checks each m_ transaction in order.
// Depends on qlu_pkg and the tabular_q_learning_update RTL.
module tabular_q_learning_update_test;
    import qlu_pkg::*;

    localparam int TABLE_DEPTH = QLU_NUM_STATES * QLU_NUM_ACTIONS;
    localparam int RANDOM_ITEMS = 1900;
    localparam int PHASES = 8;
    localparam int SETTLE_CYCLES = 32;
    localparam int CYCLE_LIMIT = 1000000;
    localparam logic [QLU_REG_W-1:0] REG_ALL_ONES = 17'h1FFFF;
    localparam logic [31:0] REWARD_MAX = 32'h7FFFFFFF;
    localparam logic [31:0] REWARD_MIN = 32'h80000000;
    localparam longint SAT_HI = 64'sd2147483647;
    localparam longint SAT_LO = -64'sd2147483648;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] value;
        logic        explored;
    } step_result_t;

    logic                     aclk;
    logic                     aresetn;
    logic                     cfg_wr_en;
    logic [QLU_CFG_IDX_W-1:0] cfg_index;
    logic [QLU_REG_W-1:0]     cfg_wdata;
    logic                     s_tvalid;
    logic                     s_tready;
    logic [QLU_S_TDATA_W-1:0] s_tdata;
    logic                     s_tuser;
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic [QLU_M_TDATA_W-1:0] m_tdata;
    logic                     m_tuser;

    logic signed [31:0] q_model [TABLE_DEPTH];
    logic [QLU_REG_W-1:0] alpha_q16;
    logic [QLU_REG_W-1:0] gamma_q16;
    logic [QLU_REG_W-1:0] epsilon_q16;
    step_result_t pending_results [$];
    int mismatches = 0;
    int unsigned cycle_count = 0;
    int burst_left = 0;

    tabular_q_learning_update DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic longint scale_q16(input longint a, input logic [QLU_REG_W-1:0] f);
        longint f_eff;
        f_eff = (f > 17'd65536) ? 64'sd65536 : longint'(f);
        return (a * f_eff + 64'sd32768) >>> 16;
    endfunction

    function automatic logic [1:0] greedy_action(input int row);
        logic [1:0] pick;
        int b;
        pick = '0;
        for (b = 1; b < QLU_NUM_ACTIONS; b++) begin
            if (q_model[row * QLU_NUM_ACTIONS + b] > q_model[row * QLU_NUM_ACTIONS + pick]) begin
                pick = b[1:0];
            end
        end
        return pick;
    endfunction

    function automatic step_result_t learn_and_select(input logic cmd,
                                                      input logic [QLU_S_TDATA_W-1:0] word);
        int s;
        int a;
        int ns;
        int row;
        longint target;
        longint cur;
        longint sum;
        logic signed [31:0] reward;
        logic [QLU_REG_W-1:0] eps_eff;
        step_result_t r;
        s = int'(word[5:0]);
        a = int'(word[7:6]);
        reward = word[39:8];
        ns = int'(word[45:40]);
        row = s;
        r.value = '0;
        if (cmd) begin
            target = longint'(reward)
                + scale_q16(longint'(q_model[ns * QLU_NUM_ACTIONS + greedy_action(ns)]), gamma_q16);
            cur = longint'(q_model[s * QLU_NUM_ACTIONS + a]);
            sum = cur + scale_q16(target - cur, alpha_q16);
            if (sum > SAT_HI) begin
                sum = SAT_HI;
            end else if (sum < SAT_LO) begin
                sum = SAT_LO;
            end
            q_model[s * QLU_NUM_ACTIONS + a] = sum[31:0];
            r.value = sum[31:0];
            row = ns;
        end
        eps_eff = (epsilon_q16 > 17'd65536) ? 17'd65536 : epsilon_q16;
        r.explored = ({1'b0, word[61:46]} < eps_eff);
        r.action = r.explored ? word[63:62] : greedy_action(row);
        return r;
    endfunction

    function automatic logic [QLU_REG_W-1:0] pick_rate();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return 17'd65536;
            2: return REG_ALL_ONES;
            3: return QLU_REG_W'($urandom_range(0, 65536));
            4: return QLU_REG_W'($urandom_range(0, REG_ALL_ONES));
            default: return QLU_REG_W'($urandom_range(60000, 65536));
        endcase
    endfunction

    always @(posedge aclk) begin : result_monitor
        step_result_t want;
        cycle_count <= cycle_count + 1;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (pending_results.size() == 0) begin
                    $error("unexpected result transaction: m_tdata %h m_tuser %b", m_tdata, m_tuser);
                    mismatches++;
                end else begin
                    want = pending_results.pop_front();
                    if (m_tdata[1:0] !== want.action) begin
                        $error("chosen_action: expected %0d, got %0d", want.action, m_tdata[1:0]);
                        mismatches++;
                    end
                    if (m_tdata[33:2] !== want.value) begin
                        $error("updated_value: expected %0d, got %0d",
                               $signed(want.value), $signed(m_tdata[33:2]));
                        mismatches++;
                    end
                    if (m_tuser !== want.explored) begin
                        $error("explored: expected %0b, got %0b", want.explored, m_tuser);
                        mismatches++;
                    end
                    if (m_tdata[39:34] !== '0) begin
                        $error("tdata pad: expected 0, got %h", m_tdata[39:34]);
                        mismatches++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                pending_results.push_back(learn_and_select(s_tuser, s_tdata));
            end
        end
    end

    always @(posedge aclk) begin
        case (cycle_count[10:9])
            2'd0: m_tready <= 1'b1;
            2'd1: m_tready <= ($urandom_range(0, 3) != 0);
            2'd2: m_tready <= (cycle_count[3:0] < 4'd5);
            default: m_tready <= ($urandom_range(0, 1) == 1);
        endcase
    end

    task automatic send_transition(input logic cmd, input logic [5:0] s, input logic [1:0] a,
                                   input logic [31:0] reward, input logic [5:0] ns,
                                   input logic [15:0] rv, input logic [1:0] ra);
        s_tuser <= cmd;
        s_tdata <= {ra, rv, ns, reward, a, s};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        burst_left--;
        if (burst_left <= 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            burst_left = $urandom_range(1, 40);
        end
    endtask

    task automatic write_register(input logic [QLU_CFG_IDX_W-1:0] idx,
                                  input logic [QLU_REG_W-1:0] value);
        cfg_index <= idx;
        cfg_wdata <= value;
        cfg_wr_en <= 1'b1;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        case (idx)
            QLU_CFG_LEARN_RATE: alpha_q16 = value;
            QLU_CFG_DISCOUNT: gamma_q16 = value;
            QLU_CFG_EXPLORE_RATE: epsilon_q16 = value;
            default: ;
        endcase
    endtask

    task automatic settle_block();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic test_select_and_learn_at_reset();
        send_transition(1'b0, 6'd0, 2'd0, 32'd0, 6'd0, 16'hFFFF, 2'd1);
        send_transition(1'b0, 6'd63, 2'd0, 32'd0, 6'd0, 16'h0000, 2'd3);
        send_transition(1'b0, 6'd7, 2'd0, 32'd0, 6'd0, 16'd6553, 2'd2);
        send_transition(1'b0, 6'd7, 2'd0, 32'd0, 6'd0, 16'd6554, 2'd2);
        send_transition(1'b1, 6'd0, 2'd3, REWARD_MAX, 6'd63, 16'hFFFF, 2'd0);
        send_transition(1'b1, 6'd63, 2'd0, REWARD_MIN, 6'd0, 16'hFFFF, 2'd0);
        send_transition(1'b1, 6'd5, 2'd2, 32'h00010000, 6'd5, 16'hFFFF, 2'd0);
        send_transition(1'b1, 6'd5, 2'd1, 32'h00200000, 6'd5, 16'hFFFF, 2'd3);
        send_transition(1'b0, 6'd5, 2'd0, 32'd0, 6'd0, 16'hFFFF, 2'd0);
        send_transition(1'b1, 6'd0, 2'd3, 32'hFFFFFFFF, 6'd0, 16'h8000, 2'd2);
        settle_block();
    endtask

    task automatic test_register_extremes();
        int a;
        write_register(QLU_CFG_LEARN_RATE, 17'd65536);
        write_register(QLU_CFG_DISCOUNT, 17'd65536);
        write_register(QLU_CFG_EXPLORE_RATE, '0);
        send_transition(1'b1, 6'd10, 2'd1, REWARD_MAX, 6'd10, 16'h0000, 2'd0);
        send_transition(1'b1, 6'd10, 2'd1, REWARD_MAX, 6'd10, 16'h0000, 2'd0);
        for (a = 0; a < QLU_NUM_ACTIONS; a++) begin
            send_transition(1'b1, 6'd12, a[1:0], REWARD_MIN, 6'd20, 16'hFFFF, 2'd0);
        end
        send_transition(1'b1, 6'd13, 2'd0, REWARD_MIN, 6'd12, 16'h0000, 2'd3);
        settle_block();
        write_register(QLU_CFG_LEARN_RATE, REG_ALL_ONES);
        write_register(QLU_CFG_DISCOUNT, REG_ALL_ONES);
        write_register(QLU_CFG_EXPLORE_RATE, REG_ALL_ONES);
        send_transition(1'b1, 6'd14, 2'd2, 32'h00030000, 6'd10, 16'hFFFF, 2'd1);
        send_transition(1'b0, 6'd10, 2'd0, 32'd0, 6'd0, 16'hFFFF, 2'd3);
        settle_block();
        write_register(QLU_CFG_LEARN_RATE, '0);
        write_register(QLU_CFG_DISCOUNT, '0);
        write_register(QLU_CFG_EXPLORE_RATE, 17'd65535);
        send_transition(1'b1, 6'd10, 2'd1, REWARD_MIN, 6'd10, 16'hFFFF, 2'd2);
        send_transition(1'b0, 6'd3, 2'd0, 32'd0, 6'd0, 16'hFFFE, 2'd2);
        settle_block();
    endtask

    task automatic test_random_phases();
        int p;
        int i;
        logic cmd;
        logic [5:0] s;
        logic [5:0] ns;
        logic [1:0] a;
        logic [1:0] ra;
        logic [31:0] r;
        logic [15:0] rv;
        for (p = 0; p < PHASES; p++) begin
            settle_block();
            if (p == 0) begin
                write_register(QLU_CFG_LEARN_RATE, QLU_LEARN_RATE_RST);
                write_register(QLU_CFG_DISCOUNT, QLU_DISCOUNT_RST);
                write_register(QLU_CFG_EXPLORE_RATE, QLU_EXPLORE_RATE_RST);
            end else begin
                write_register(QLU_CFG_LEARN_RATE, pick_rate());
                write_register(QLU_CFG_DISCOUNT, pick_rate());
                write_register(QLU_CFG_EXPLORE_RATE, pick_rate());
            end
            for (i = 0; i < RANDOM_ITEMS / PHASES; i++) begin
                if (p == 3 && i == 100) begin
                    settle_block();
                end
                cmd = ($urandom_range(0, 3) != 0);
                s = ($urandom_range(0, 3) != 0) ? 6'($urandom_range(0, 7))
                                                : 6'($urandom_range(0, 63));
                if ($urandom_range(0, 7) == 0) begin
                    ns = s;
                end else begin
                    ns = ($urandom_range(0, 3) != 0) ? 6'($urandom_range(0, 7))
                                                     : 6'($urandom_range(0, 63));
                end
                a = 2'($urandom_range(0, 3));
                ra = 2'($urandom_range(0, 3));
                case ($urandom_range(0, 9))
                    0: r = $urandom_range(0, 1) ? REWARD_MAX : REWARD_MIN;
                    1, 2: r = $urandom;
                    default: r = $urandom_range(0, 32'h00100000) - 32'h00080000;
                endcase
                if ($urandom_range(0, 7) == 0) begin
                    rv = 16'(32'(epsilon_q16[15:0]) + $urandom_range(0, 2) - 32'd1);
                end else begin
                    rv = 16'($urandom_range(0, 16'hFFFF));
                end
                send_transition(cmd, s, a, r, ns, rv, ra);
            end
        end
    endtask

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) @(posedge aclk);
        $display("tabular_q_learning_update verification failed");
        $finish;
    end

    initial begin
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        foreach (q_model[i]) q_model[i] = '0;
        alpha_q16 = QLU_LEARN_RATE_RST;
        gamma_q16 = QLU_DISCOUNT_RST;
        epsilon_q16 = QLU_EXPLORE_RATE_RST;
        burst_left = $urandom_range(1, 40);
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_select_and_learn_at_reset();
        test_register_extremes();
        test_random_phases();
        settle_block();
        if (mismatches == 0) begin
            $display("tabular_q_learning_update verification clean");
        end else begin
            $display("tabular_q_learning_update verification failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/qlu_pkg.sv
rtl/qlu_ram.sv
rtl/qlu_ctrl.sv
rtl/qlu_datapath.sv
rtl/tabular_q_learning_update.sv
test/tabular_q_learning_update_test.sv
